FILE: design/cursor_array_list_defines.svh
// Assertion macros shared by the cursor array list checker.
`ifndef CURSOR_ARRAY_LIST_DEFINES_SVH
`define CURSOR_ARRAY_LIST_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define CAL_ASSERT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define CAL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/cal_pkg.sv
// Types, codes and constants of the cursor array list.
package cal_pkg;

    localparam int DATA_W     = 32;
    localparam int POS_W      = 11;
    localparam int OP_W       = 3;
    localparam int ST_W       = 2;
    localparam int LIST_DEPTH = 1024;

    localparam logic [POS_W-1:0] CAP_RESET = 11'd1024;

    localparam logic [OP_W-1:0] OP_INSERT = 3'd0;
    localparam logic [OP_W-1:0] OP_REMOVE = 3'd1;
    localparam logic [OP_W-1:0] OP_COUNT  = 3'd2;
    localparam logic [OP_W-1:0] OP_PREV   = 3'd3;
    localparam logic [OP_W-1:0] OP_NEXT   = 3'd4;
    localparam logic [OP_W-1:0] OP_START  = 3'd5;
    localparam logic [OP_W-1:0] OP_END    = 3'd6;

    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
    localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]          opcode;
        logic signed [DATA_W-1:0] operand_value;
    } req_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] result_value;
        logic [ST_W-1:0]          status;
        logic [POS_W-1:0]         cursor_position;
        logic [POS_W-1:0]         list_length;
    } rsp_t;

endpackage

FILE: design/cursor_array_list.sv
// Insert and remove walk length - cursor entries, count walks length entries in S_WALK;
// S_FIN and S_DONE follow before the result word. Cursor moves and refused requests go
// from accept straight to S_DONE. One request at a time; the walk moves one entry per
// cycle through the single read port of the entry memory.
// Reset clears length and cursor and sets the capacity register to 1024; the entry
// memory is not cleared and the block is ready right after reset.
module cursor_array_list
    import cal_pkg::*;
#(
    parameter int DEPTH = LIST_DEPTH
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  req_t             in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output rsp_t             out_data,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [POS_W-1:0] cfg_data
);

    localparam int AW = $clog2(DEPTH);
    localparam int LW = $clog2(DEPTH + 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_WALK = 3'd1;
    localparam logic [2:0] S_FIN  = 3'd2;
    localparam logic [2:0] S_DONE = 3'd3;

    logic [DATA_W-1:0] mem [DEPTH];

    logic [2:0]        state_reg;
    logic [OP_W-1:0]   op_reg;
    logic [DATA_W-1:0] val_reg;
    logic [LW-1:0]     length_reg;
    logic [LW-1:0]     cursor_reg;
    logic [POS_W-1:0]  cap_reg;
    logic [LW-1:0]     rem_reg;
    logic [AW-1:0]     ptr_reg;
    logic              pend_reg;
    logic [AW-1:0]     pend_addr_reg;
    logic [DATA_W-1:0] rdata_reg;
    logic [DATA_W-1:0] acc_reg;
    logic [ST_W-1:0]   status_reg;
    rsp_t              out_reg;
    logic              out_valid_reg;

    logic              full;
    logic              mem_re;
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [DATA_W-1:0] mem_wdata;
    logic [AW-1:0]     cur_addr;

    assign in_ready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    assign cur_addr = cursor_reg[AW-1:0];
    assign full     = (length_reg >= LW'(DEPTH)) || (32'(length_reg) >= 32'(cap_reg));
    assign mem_re   = (state_reg == S_WALK) && (rem_reg != '0);

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = pend_addr_reg;
        mem_wdata = rdata_reg;
        if (pend_reg)
        begin
            if (op_reg == OP_INSERT)
            begin
                mem_we    = 1'b1;
                mem_waddr = pend_addr_reg + AW'(1);
            end
            else if (op_reg == OP_REMOVE && pend_addr_reg != cur_addr)
            begin
                mem_we    = 1'b1;
                mem_waddr = pend_addr_reg - AW'(1);
            end
        end
        else if (state_reg == S_FIN && op_reg == OP_INSERT)
        begin
            mem_we    = 1'b1;
            mem_waddr = cur_addr;
            mem_wdata = val_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= mem[ptr_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            length_reg    <= '0;
            cursor_reg    <= '0;
            cap_reg       <= CAP_RESET;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                cap_reg <= cfg_data;
            end

            pend_reg      <= mem_re;
            pend_addr_reg <= ptr_reg;

            if (pend_reg)
            begin
                if (op_reg == OP_COUNT && rdata_reg == val_reg)
                begin
                    acc_reg <= acc_reg + DATA_W'(1);
                end
                if (op_reg == OP_REMOVE && pend_addr_reg == cur_addr)
                begin
                    acc_reg <= rdata_reg;
                end
            end

            if (out_valid_reg && out_ready && state_reg != S_DONE)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        op_reg     <= in_data.opcode;
                        val_reg    <= in_data.operand_value;
                        acc_reg    <= '0;
                        status_reg <= ST_OK;
                        state_reg  <= S_DONE;
                        unique case (in_data.opcode)
                            OP_INSERT:
                            begin
                                if (full)
                                begin
                                    status_reg <= ST_FULL;
                                end
                                else
                                begin
                                    ptr_reg   <= AW'(length_reg - LW'(1));
                                    rem_reg   <= length_reg - cursor_reg;
                                    state_reg <= S_WALK;
                                end
                            end
                            OP_REMOVE:
                            begin
                                if (cursor_reg >= length_reg)
                                begin
                                    status_reg <= ST_EMPTY;
                                end
                                else
                                begin
                                    ptr_reg   <= cur_addr;
                                    rem_reg   <= length_reg - cursor_reg;
                                    state_reg <= S_WALK;
                                end
                            end
                            OP_COUNT:
                            begin
                                ptr_reg   <= '0;
                                rem_reg   <= length_reg;
                                state_reg <= S_WALK;
                            end
                            OP_PREV:
                            begin
                                if (cursor_reg != '0)
                                begin
                                    cursor_reg <= cursor_reg - LW'(1);
                                end
                            end
                            OP_NEXT:
                            begin
                                if (cursor_reg < length_reg)
                                begin
                                    cursor_reg <= cursor_reg + LW'(1);
                                end
                            end
                            OP_START:
                            begin
                                cursor_reg <= '0;
                            end
                            OP_END:
                            begin
                                cursor_reg <= length_reg;
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                S_WALK:
                begin
                    if (rem_reg != '0)
                    begin
                        rem_reg <= rem_reg - LW'(1);
                        if (op_reg == OP_INSERT)
                        begin
                            ptr_reg <= ptr_reg - AW'(1);
                        end
                        else
                        begin
                            ptr_reg <= ptr_reg + AW'(1);
                        end
                    end
                    else
                    begin
                        state_reg <= S_FIN;
                    end
                end
                S_FIN:
                begin
                    if (op_reg == OP_INSERT)
                    begin
                        length_reg <= length_reg + LW'(1);
                    end
                    else if (op_reg == OP_REMOVE)
                    begin
                        length_reg <= length_reg - LW'(1);
                    end
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_reg.result_value    <= acc_reg;
                        out_reg.status          <= status_reg;
                        out_reg.cursor_position <= POS_W'(cursor_reg);
                        out_reg.list_length     <= POS_W'(length_reg);
                        out_valid_reg           <= 1'b1;
                        state_reg               <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

FILE: design/cal_checker.sv
// Port-level checks of the cursor array list and their bind.
`include "cursor_array_list_defines.svh"

module cal_checker
    import cal_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic out_valid,
    input logic out_ready,
    input rsp_t out_data
);

    `CAL_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "stalled result word changed")
    `CAL_ASSERT(a_cursor_in_list, out_valid, out_data.cursor_position <= out_data.list_length, "cursor beyond list length")
    `CAL_ASSERT(a_status_code, out_valid, out_data.status == ST_OK || out_data.status == ST_FULL || out_data.status == ST_EMPTY, "unknown status code")
    `CAL_ASSERT(a_fail_zero, out_valid && out_data.status != ST_OK, out_data.result_value == '0, "failed request carries a value")

endmodule

bind cursor_array_list cal_checker u_cal_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
